[rtl/glt_pkg.sv]
package glt_pkg;

    // Table size and widths
    localparam int GLT_TABLE_SLOTS = 256;
    localparam int ADDR_W          = 32;
    localparam int TIME_W          = 32;
    localparam int SLOT_OUT_W      = 8;
    localparam int FREED_W         = 8;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int IN_TDATA_W      = 96;
    localparam int OUT_TDATA_W     = 48;

    // Register reset values
    localparam logic [7:0]        SUBNET_RESET   = 8'd0;
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60000;
    localparam logic [TIME_W-1:0] EXPIRY_RESET   = 32'd1260000;

    // Fixed leading bytes of the virtual subnet 169.254.x.0
    localparam logic [7:0] VIP_FIRST_BYTE  = 8'd169;
    localparam logic [7:0] VIP_SECOND_BYTE = 8'd254;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_REQUEST   = 3'd0,
        OP_KEEPALIVE = 3'd1,
        OP_CHECK     = 3'd2,
        OP_RESOLVE   = 3'd3,
        OP_TICK      = 3'd4
    } glt_op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_UNKNOWN    = 2'd2,
        STAT_UNRESOLVED = 2'd3
    } glt_status_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SUBNET   = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_EXPIRY   = 2'd2
    } glt_cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_LOOK,
        S_FINISH,
        S_DELIVER
    } glt_state_t;

    // One lease entry as held in the memory
    typedef struct packed {
        logic [ADDR_W-1:0] client;
        logic [TIME_W-1:0] alive_time;
    } glt_entry_t;

    // Memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } glt_mem_ctl_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0]        subnet;
        logic [TIME_W-1:0] sweep_interval;
        logic [TIME_W-1:0] lease_expiry;
    } glt_cfg_t;

    // One result
    typedef struct packed {
        glt_status_t           status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     client;
        logic [FREED_W-1:0]    freed;
    } glt_result_t;

endpackage

[rtl/glt_mem.sv]
module glt_mem #(
    parameter int TABLE_SLOTS = glt_pkg::GLT_TABLE_SLOTS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                 clk,
    input  glt_pkg::glt_mem_ctl_t ctl,
    input  logic [SLOT_W-1:0]    rd_addr,
    input  logic [SLOT_W-1:0]    wr_addr,
    input  glt_pkg::glt_entry_t  wr_data,
    output glt_pkg::glt_entry_t  rd_data
);
    import glt_pkg::*;

    glt_entry_t mem_reg [TABLE_SLOTS];
    glt_entry_t rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/glt_ctrl.sv]
module glt_ctrl #(
    parameter int TABLE_SLOTS = glt_pkg::GLT_TABLE_SLOTS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  glt_pkg::glt_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  glt_pkg::glt_op_t            in_op,
    input  logic [glt_pkg::ADDR_W-1:0]  in_client,
    input  logic [glt_pkg::ADDR_W-1:0]  in_vip,
    input  logic [glt_pkg::TIME_W-1:0]  in_now,
    output logic                        res_valid,
    input  logic                        res_ready,
    output glt_pkg::glt_result_t        res,
    output glt_pkg::glt_mem_ctl_t       mem_ctl,
    output logic [SLOT_W-1:0]           mem_rd_addr,
    output logic [SLOT_W-1:0]           mem_wr_addr,
    output glt_pkg::glt_entry_t         mem_wr_data,
    input  glt_pkg::glt_entry_t         mem_rd_data
);
    import glt_pkg::*;

    localparam logic [SLOT_W-1:0]     FIRST_SLOT   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]     LAST_SLOT    = SLOT_W'(TABLE_SLOTS - 2);
    localparam logic [SLOT_OUT_W-1:0] LAST_BYTE_OK = SLOT_OUT_W'(TABLE_SLOTS - 2);

    glt_state_t state_reg, state_next;

    glt_op_t             op_reg, op_next;
    logic [ADDR_W-1:0]   client_reg, client_next;
    logic [ADDR_W-1:0]   vip_reg, vip_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   last_sweep_reg, last_sweep_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic                issue_done_reg, issue_done_next;
    logic                cmp_en_reg, cmp_en_next;
    logic [SLOT_W-1:0]   cmp_slot_reg, cmp_slot_next;
    logic                match_reg, match_next;
    logic [SLOT_W-1:0]   match_slot_reg, match_slot_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic [FREED_W-1:0]  freed_reg, freed_next;
    glt_result_t         res_reg, res_next;

    logic                accept;
    logic                issue;
    logic                hit;
    logic                expired;
    logic                sweep_due;
    logic                last_usable;
    logic                net_ok;
    logic [SLOT_W-1:0]   last_slot;
    logic                do_write;
    logic [SLOT_W-1:0]   write_slot;

    assign accept    = in_valid && in_ready;
    assign issue     = mem_ctl.rd_en && (state_reg == S_SCAN);
    assign last_slot = vip_reg[SLOT_W-1:0];

    // Comparisons on the entry just read back
    assign hit = cmp_en_reg && valid_reg[cmp_slot_reg] && (mem_rd_data.client == client_reg);
    assign expired = cmp_en_reg && valid_reg[cmp_slot_reg] &&
                     (({1'b0, mem_rd_data.alive_time} + {1'b0, cfg.lease_expiry})
                      < {1'b0, now_reg});
    assign sweep_due = ({1'b0, last_sweep_reg} + {1'b0, cfg.sweep_interval})
                       < {1'b0, now_reg};

    // Destination byte and subnet checks
    assign last_usable = (vip_reg[7:0] != 8'd0) && (vip_reg[7:0] <= LAST_BYTE_OK);
    assign net_ok = (vip_reg[31:24] == VIP_FIRST_BYTE) && (vip_reg[23:16] == VIP_SECOND_BYTE)
                    && (vip_reg[15:8] == cfg.subnet);

    // A grant to a new client or a refresh of a known one writes the entry
    always_comb
    begin
        do_write   = 1'b0;
        write_slot = match_slot_reg;
        case (op_reg)
            OP_REQUEST:
            begin
                do_write   = !match_reg && free_found_reg;
                write_slot = free_slot_reg;
            end
            OP_KEEPALIVE:
            begin
                do_write   = match_reg;
                write_slot = match_slot_reg;
            end
            default:
            begin
                do_write   = 1'b0;
                write_slot = match_slot_reg;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op) inside
                        OP_REQUEST, OP_KEEPALIVE: state_next = S_SCAN;
                        OP_CHECK, OP_RESOLVE:     state_next = S_LOOK;
                        OP_TICK:                  state_next = S_TICK;
                        default:                  state_next = S_FINISH;
                    endcase
                end
            end
            S_TICK:
            begin
                state_next = sweep_due ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if ((op_reg != OP_TICK) && hit)
                begin
                    state_next = S_FINISH;
                end
                else if (issue_done_reg && !cmp_en_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOOK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_rd_addr   = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN:
            begin
                mem_ctl.rd_en = !issue_done_reg;
            end
            S_LOOK:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = last_slot;
            end
            S_FINISH:
            begin
                mem_ctl.wr_en = do_write;
            end
            S_DELIVER:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign mem_wr_addr            = write_slot;
    assign mem_wr_data.client     = client_reg;
    assign mem_wr_data.alive_time = now_reg;
    assign res                    = res_reg;

    // Datapath next values
    always_comb
    begin
        op_next         = op_reg;
        client_next     = client_reg;
        vip_next        = vip_reg;
        now_next        = now_reg;
        last_sweep_next = last_sweep_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        issue_done_next = issue_done_reg;
        cmp_en_next     = 1'b0;
        cmp_slot_next   = cmp_slot_reg;
        match_next      = match_reg;
        match_slot_next = match_slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        freed_next      = freed_reg;
        res_next        = res_reg;

        // Take a new item in and restart the scan
        if (accept)
        begin
            op_next         = in_op;
            client_next     = in_client;
            vip_next        = in_vip;
            now_next        = in_now;
            scan_next       = FIRST_SLOT;
            issue_done_next = 1'b0;
            match_next      = 1'b0;
            free_found_next = 1'b0;
            freed_next      = '0;
        end

        // A due sweep moves the sweep time on
        if ((state_reg == S_TICK) && sweep_due)
        begin
            last_sweep_next = now_reg;
        end

        // Issue side of the scan: one read per cycle, lowest free slot noted
        if (issue)
        begin
            scan_next       = SLOT_W'(scan_reg + 1'b1);
            issue_done_next = (scan_reg == LAST_SLOT);
            cmp_en_next     = 1'b1;
            cmp_slot_next   = scan_reg;
            if ((op_reg == OP_REQUEST) && !free_found_reg && !valid_reg[scan_reg])
            begin
                free_found_next = 1'b1;
                free_slot_next  = scan_reg;
            end
        end

        // Compare side of the scan
        if (state_reg == S_SCAN)
        begin
            if (op_reg == OP_TICK)
            begin
                if (expired)
                begin
                    valid_next[cmp_slot_reg] = 1'b0;
                    freed_next               = FREED_W'(freed_reg + 1'b1);
                end
            end
            else if (hit)
            begin
                match_next      = 1'b1;
                match_slot_next = cmp_slot_reg;
            end
        end

        // Form the result
        if (state_reg == S_FINISH)
        begin
            res_next.status = STAT_OK;
            res_next.slot   = '0;
            res_next.client = '0;
            res_next.freed  = '0;
            case (op_reg)
                OP_REQUEST:
                begin
                    if (match_reg)
                    begin
                        res_next.slot = SLOT_OUT_W'(match_slot_reg);
                    end
                    else if (free_found_reg)
                    begin
                        res_next.slot             = SLOT_OUT_W'(free_slot_reg);
                        valid_next[free_slot_reg] = 1'b1;
                    end
                    else
                    begin
                        res_next.status = STAT_FULL;
                    end
                end
                OP_KEEPALIVE:
                begin
                    if (match_reg)
                    begin
                        res_next.slot = SLOT_OUT_W'(match_slot_reg);
                    end
                    else
                    begin
                        res_next.status = STAT_UNKNOWN;
                    end
                end
                OP_CHECK:
                begin
                    if (net_ok && last_usable && valid_reg[last_slot] &&
                        (mem_rd_data.client == client_reg))
                    begin
                        res_next.slot = vip_reg[7:0];
                    end
                    else
                    begin
                        res_next.status = STAT_UNKNOWN;
                    end
                end
                OP_RESOLVE:
                begin
                    if (last_usable && valid_reg[last_slot])
                    begin
                        res_next.slot   = vip_reg[7:0];
                        res_next.client = mem_rd_data.client;
                    end
                    else
                    begin
                        res_next.status = STAT_UNRESOLVED;
                    end
                end
                OP_TICK:
                begin
                    res_next.freed = freed_reg;
                end
                default:
                begin
                    res_next.status = STAT_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            last_sweep_reg <= '0;
            issue_done_reg <= 1'b0;
            cmp_en_reg     <= 1'b0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            last_sweep_reg <= last_sweep_next;
            issue_done_reg <= issue_done_next;
            cmp_en_reg     <= cmp_en_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        client_reg     <= client_next;
        vip_reg        <= vip_next;
        now_reg        <= now_next;
        scan_reg       <= scan_next;
        cmp_slot_reg   <= cmp_slot_next;
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        freed_reg      <= freed_next;
        res_reg        <= res_next;
    end

endmodule

[rtl/gateway_lease_table_top.sv]
// Channel  Direction  Handshake            Contents
// s_*      in         s_tvalid / s_tready  one request: operation, client, address, time
// m_*      out        m_tvalid / m_tready  one result per request
// cfg_*    in         cfg_valid / cfg_ready register write, always ready
//
// Requests are served one at a time; after each result the sequencer returns to
// idle before the next is taken. A request or keep-alive reads one slot at a time
// from 1 to TABLE_SLOTS - 2 and stops early on a match; a tick scans the same slots
// only when a sweep is due; check and resolve read the one slot that they name.
// Reset frees every slot at once through the valid flags; no clearing pass.
// A result waits in the output register; a second one stalls the sequencer.
module gateway_lease_table_top #(
    parameter int TABLE_SLOTS = glt_pkg::GLT_TABLE_SLOTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request: tuser = operation
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [glt_pkg::OP_W-1:0]            s_tuser,
    // Request: tdata = client_ip, virtual_ip, now_ms
    input  logic [glt_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Result: tuser = status
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [glt_pkg::STATUS_W-1:0]        m_tuser,
    // Result: tdata = slot_index, client_ip_out, freed_count
    output logic [glt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [glt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import glt_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    glt_cfg_t          cfg_reg, cfg_next;
    logic              out_valid_reg, out_valid_next;
    glt_result_t       out_res_reg, out_res_next;

    logic              res_valid;
    logic              res_ready;
    glt_result_t       res;
    glt_mem_ctl_t      mem_ctl;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [SLOT_W-1:0] mem_wr_addr;
    glt_entry_t        mem_wr_data;
    glt_entry_t        mem_rd_data;

    // Configuration register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SUBNET:   cfg_next.subnet         = cfg_data[7:0];
                CFG_INTERVAL: cfg_next.sweep_interval = cfg_data;
                CFG_EXPIRY:   cfg_next.lease_expiry   = cfg_data;
                default:      cfg_next                = cfg_reg;
            endcase
        end
    end

    // Output register: loads when empty or being emptied
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.subnet         <= SUBNET_RESET;
            cfg_reg.sweep_interval <= INTERVAL_RESET;
            cfg_reg.lease_expiry   <= EXPIRY_RESET;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {out_res_reg.freed, out_res_reg.client, out_res_reg.slot};

    // Sequencer
    glt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (glt_op_t'(s_tuser)),
        .in_client   (s_tdata[31:0]),
        .in_vip      (s_tdata[63:32]),
        .in_now      (s_tdata[95:64]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    // Lease memory: client address and keep-alive time per slot
    glt_mem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

endmodule

[rtl/glt_checker.sv]
module glt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [glt_pkg::STATUS_W-1:0]        m_tuser,
    input  logic [glt_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import glt_pkg::*;

    // A stalled result holds its contents
    result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Requests are served one at a time: busy right after a transaction
    busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    // A full table grants nothing and frees nothing
    full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[7:0] == 8'd0) &&
        (m_tdata[47:40] == 8'd0))
        else $error("table full result carries a slot");

    // An unresolved destination carries no slot and no client
    unresolved_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_UNRESOLVED) |-> (m_tdata[39:0] == 40'd0))
        else $error("unresolved result carries a slot or client");

    // A sweep can never free more than the usable slots
    freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:40] != 8'hFF))
        else $error("freed count out of range");

endmodule

bind gateway_lease_table_top glt_checker u_glt_checker (.*);

[verif/gateway_lease_table_top_tb.sv]
`timescale 1ns / 100ps

module gateway_lease_table_top_tb;

    import glt_pkg::*;

    localparam int SLOTS       = GLT_TABLE_SLOTS;
    localparam int LAST_SLOT   = SLOTS - 2;
    localparam int CYCLE_LIMIT = 4000000;

    // Lease table predictor and the queue of results it expects.
    class lease_scoreboard;
        bit          lease_valid[SLOTS];
        bit [31:0]   lease_client[SLOTS];
        bit [31:0]   lease_alive[SLOTS];
        bit [31:0]   last_sweep;
        bit [7:0]    subnet;
        bit [31:0]   sweep_interval;
        bit [31:0]   lease_expiry;
        glt_result_t expected_q[$];
        int          errors;

        function new();
            foreach (lease_valid[i])
            begin
                lease_valid[i]  = 1'b0;
                lease_client[i] = '0;
                lease_alive[i]  = '0;
            end
            last_sweep     = '0;
            subnet         = SUBNET_RESET;
            sweep_interval = INTERVAL_RESET;
            lease_expiry   = EXPIRY_RESET;
            errors         = 0;
        endfunction

        function void write_reg(glt_cfg_index_t idx, bit [31:0] data);
            case (idx)
                CFG_SUBNET:   subnet = data[7:0];
                CFG_INTERVAL: sweep_interval = data;
                CFG_EXPIRY:   lease_expiry = data;
                default:      ;
            endcase
        endfunction

        // Slot that holds the client, or 0 when none does.
        function int find_holder(bit [31:0] addr);
            for (int s = 1; s <= LAST_SLOT; s++)
                if (lease_valid[s] && lease_client[s] == addr)
                    return s;
            return 0;
        endfunction

        // A leased slot chosen at random, or 0 when the table is empty.
        function int pick_held_slot();
            int start;
            int s;
            start = $urandom_range(1, LAST_SLOT);
            for (int k = 0; k < LAST_SLOT; k++)
            begin
                s = 1 + (start - 1 + k) % LAST_SLOT;
                if (lease_valid[s])
                    return s;
            end
            return 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted request and update the table.
        function void note_request(bit [2:0] op, bit [31:0] caddr, bit [31:0] vip,
                                   bit [31:0] now);
            glt_result_t r;
            int          s;
            int          freed;
            bit [7:0]    last_byte;
            r         = '0;
            r.status  = STAT_OK;
            last_byte = vip[7:0];
            case (op)
                OP_REQUEST:
                begin
                    s = find_holder(caddr);
                    if (s == 0)
                    begin
                        s = 1;
                        while (s <= LAST_SLOT && lease_valid[s])
                            s++;
                        if (s <= LAST_SLOT)
                        begin
                            lease_valid[s]  = 1'b1;
                            lease_client[s] = caddr;
                            lease_alive[s]  = now;
                        end
                        else
                        begin
                            r.status = STAT_FULL;
                            s = 0;
                        end
                    end
                    r.slot = s[7:0];
                end
                OP_KEEPALIVE:
                begin
                    s = find_holder(caddr);
                    if (s != 0)
                    begin
                        lease_alive[s] = now;
                        r.slot = s[7:0];
                    end
                    else
                        r.status = STAT_UNKNOWN;
                end
                OP_CHECK:
                begin
                    if (vip[31:24] == VIP_FIRST_BYTE && vip[23:16] == VIP_SECOND_BYTE &&
                        vip[15:8] == subnet && last_byte >= 1 && last_byte <= LAST_SLOT &&
                        lease_valid[last_byte] && lease_client[last_byte] == caddr)
                        r.slot = last_byte;
                    else
                        r.status = STAT_UNKNOWN;
                end
                OP_RESOLVE:
                begin
                    if (last_byte >= 1 && last_byte <= LAST_SLOT && lease_valid[last_byte])
                    begin
                        r.slot   = last_byte;
                        r.client = lease_client[last_byte];
                    end
                    else
                        r.status = STAT_UNRESOLVED;
                end
                OP_TICK:
                begin
                    freed = 0;
                    // Both sums are taken at 33 bits so that they never wrap.
                    if ({1'b0, last_sweep} + {1'b0, sweep_interval} < {1'b0, now})
                    begin
                        last_sweep = now;
                        for (int k = 1; k <= LAST_SLOT; k++)
                            if (lease_valid[k] &&
                                {1'b0, lease_alive[k]} + {1'b0, lease_expiry} < {1'b0, now})
                            begin
                                lease_valid[k] = 1'b0;
                                freed++;
                            end
                    end
                    r.freed = freed[7:0];
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(bit [1:0] st, bit [47:0] data);
            glt_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d data %h",
                         $time, st, data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st != e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (data[7:0] != e.slot)
            begin
                $display("%0t: slot_index expected %0d actual %0d", $time, e.slot, data[7:0]);
                errors++;
            end
            if (data[39:8] != e.client)
            begin
                $display("%0t: resolved client expected %h actual %h",
                         $time, e.client, data[39:8]);
                errors++;
            end
            if (data[47:40] != e.freed)
            begin
                $display("%0t: freed_count expected %0d actual %0d",
                         $time, e.freed, data[47:40]);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OP_W-1:0]         s_tuser;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [STATUS_W-1:0]     m_tuser;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    lease_scoreboard sb;
    int              sender_gap_pct = 0;
    int              stall_pct = 0;
    int              cycle_count = 0;
    bit [31:0]       now_ms;
    bit [31:0]       pool[400];

    gateway_lease_table_top #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL gateway_lease_table_top");
            $finish;
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Every result transaction is checked against the predictions.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);

    // Present one request and hold it until the block takes it; s_tvalid stays high.
    task automatic send_item(bit [2:0] op, bit [31:0] caddr, bit [31:0] vip, bit [31:0] now);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, vip, caddr};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, caddr, vip, now);
    endtask

    task automatic write_cfg(glt_cfg_index_t idx, bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One phase of random traffic under one register setting and idling mode.
    task automatic run_phase(int mode, bit [7:0] sn, bit [31:0] iv, bit [31:0] ex,
                             int n_items, int pool_size, int step_max, int req_pct);
        int        r;
        int        s;
        int        next_req;
        bit [2:0]  op;
        bit [31:0] caddr;
        bit [31:0] vip;
        bit [32:0] t;
        case (mode)
            1:       begin sender_gap_pct = 65; stall_pct = 0;  end
            2:       begin sender_gap_pct = 0;  stall_pct = 65; end
            3:       begin sender_gap_pct = 17; stall_pct = 17; end
            default: begin sender_gap_pct = 0;  stall_pct = 0;  end
        endcase
        write_cfg(CFG_SUBNET, {24'd0, sn});
        write_cfg(CFG_INTERVAL, iv);
        write_cfg(CFG_EXPIRY, ex);
        for (int k = 0; k < pool_size; k++)
            pool[k] = $urandom;
        next_req = 0;
        for (int k = 0; k < n_items; k++)
        begin
            t = {1'b0, now_ms} + $urandom_range(0, step_max);
            now_ms = t[32] ? 32'hFFFF_FFFF : t[31:0];
            if ($urandom_range(0, 99) < 3)
                now_ms = $urandom;
            caddr = pool[$urandom_range(0, pool_size - 1)];
            vip = $urandom;
            if ($urandom_range(0, 99) < 5)
                caddr = $urandom;
            r = $urandom_range(0, 99);
            if (r < req_pct)
                op = OP_REQUEST;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 27)
                    op = OP_KEEPALIVE;
                else if (r < 54)
                    op = OP_CHECK;
                else if (r < 76)
                    op = OP_RESOLVE;
                else if (r < 95)
                    op = OP_TICK;
                else
                    op = 3'($urandom_range(5, 7));
            end
            // A pool larger than the table is walked in order so that it fills up.
            if (op == OP_REQUEST && pool_size > LAST_SLOT)
            begin
                caddr = pool[next_req % pool_size];
                next_req++;
            end
            if (op == OP_CHECK)
            begin
                s = sb.pick_held_slot();
                if (s != 0)
                begin
                    caddr = sb.lease_client[s];
                    vip = {VIP_FIRST_BYTE, VIP_SECOND_BYTE, sb.subnet, s[7:0]};
                end
                // Break a well-formed check in one way at a time.
                if (s == 0 || $urandom_range(0, 99) < 30)
                    case ($urandom_range(0, 5))
                        0: caddr = $urandom;
                        1: vip[31:24] = vip[31:24] ^ 8'($urandom_range(1, 255));
                        2: vip[23:16] = vip[23:16] ^ 8'($urandom_range(1, 255));
                        3: vip[15:8] = vip[15:8] ^ 8'($urandom_range(1, 255));
                        4: vip[7:0] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                        default: vip = {VIP_FIRST_BYTE, VIP_SECOND_BYTE, sb.subnet,
                                        8'($urandom_range(1, LAST_SLOT))};
                    endcase
            end
            if (op == OP_RESOLVE)
            begin
                s = sb.pick_held_slot();
                if (s != 0 && $urandom_range(0, 99) < 70)
                    vip[7:0] = s[7:0];
                else if ($urandom_range(0, 99) < 40)
                    vip[7:0] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
            end
            send_item(op, caddr, vip, now_ms);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset register values.
        send_item(OP_RESOLVE,   32'h0,         32'h0,         32'd0);
        send_item(OP_KEEPALIVE, 32'hFFFF_FFFF, 32'h0,         32'd0);
        send_item(OP_REQUEST,   32'h0,         32'hFFFF_FFFF, 32'd0);
        send_item(OP_REQUEST,   32'hFFFF_FFFF, 32'h0,         32'd10);
        // Already leased: same slot, time unchanged.
        send_item(OP_REQUEST,   32'h0,         32'h0,         32'd20);
        send_item(OP_KEEPALIVE, 32'hFFFF_FFFF, 32'h0,         32'd30);
        send_item(OP_CHECK,     32'h0,         32'hA9FE_0001, 32'd40);
        // Failing checks: wrong sender, unusable last byte, wrong prefix, free slot.
        send_item(OP_CHECK,     32'hFFFF_FFFF, 32'hA9FE_0001, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA9FE_0000, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA9FE_00FF, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA8FE_0001, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA9FF_0001, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA9FE_0101, 32'd40);
        send_item(OP_CHECK,     32'h0,         32'hA9FE_0003, 32'd40);
        send_item(OP_RESOLVE,   32'h0,         32'hFFFF_FF02, 32'd40);
        send_item(OP_RESOLVE,   32'h0,         32'h0000_00FF, 32'd40);
        send_item(OP_RESOLVE,   32'h0,         32'h0000_0003, 32'd40);
        // Tick exactly at the interval does not sweep; one later does.
        send_item(OP_TICK,      32'h0,         32'h0,         32'd60000);
        send_item(OP_TICK,      32'h0,         32'h0,         32'd60001);
        send_item(3'd5,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(3'd6,         32'h1234_5678, 32'h9ABC_DEF0, 32'd50);
        send_item(3'd7,         32'h0,         32'h0,         32'd50);
        send_item(OP_TICK,      32'h0,         32'h0,         32'd1260020);
        send_item(OP_TICK,      32'h0,         32'h0,         32'd2600000);
        send_item(OP_REQUEST,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd2600000);
        drain();

        // Random phases; the near-overflow time phase runs last.
        now_ms = 32'd2600000;
        run_phase(0, 8'hA5, 32'd1000,       32'd5000,       300, 24,  200, 25);
        run_phase(1, 8'hFF, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  350, 300, 50,  90);
        run_phase(2, 8'h00, 32'd1,          32'd1,          250, 30,  5,   25);
        run_phase(3, 8'($urandom), 32'd100, 32'd2000,       400, 40,  100, 25);
        run_phase(1, 8'($urandom), 32'($urandom_range(1, 20000)),
                  32'($urandom_range(1, 200000)),           350, 40,  500, 25);
        now_ms = 32'hFFFF_E000;
        run_phase(2, 8'($urandom), 32'd3000, 32'hFFFF_FFFE, 300, 30,  60,  25);

        repeat (SLOTS + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS gateway_lease_table_top");
        else
            $display("FAIL gateway_lease_table_top");
        $finish;
    end

endmodule

[sim.f]
rtl/glt_pkg.sv
rtl/glt_mem.sv
rtl/glt_ctrl.sv
rtl/gateway_lease_table_top.sv
rtl/glt_checker.sv
verif/gateway_lease_table_top_tb.sv
